/* design/assembly_line_encoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the encoder's line queue; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLY_LINE_ENCODER_UNIT_ASSERT_SVH
`define ASSEMBLY_LINE_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define ALE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ALE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ALE_ASSERT(lbl, clk, rst_n, prop, msg)
`define ALE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

/* design/ale_pkg.sv */
// ----------------------------------------------------------------------------
// ale_pkg
// Types, constants and mnemonic tables of the assembly line encoder.
// ----------------------------------------------------------------------------
package ale_pkg;

	localparam int MAX_TOKEN_CHARS = 3;
	localparam int TOKEN_STORE     = 3;
	localparam int TOKEN_LIMIT     = (MAX_TOKEN_CHARS < TOKEN_STORE) ?
	                                 MAX_TOKEN_CHARS : TOKEN_STORE;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} in_t;

	typedef struct packed {
		logic [15:0] machine_word;
		logic        comp_unknown;
		logic        address_overflow;
	} out_t;

	typedef struct packed {
		logic [23:0] chars;
		logic [1:0]  len;
		logic        too_long;
	} tok_t;

	// One finished line, handed from the front to the back.
	typedef struct packed {
		logic        is_addr;
		logic [15:0] addr;
		logic        addr_over;
		tok_t        dest;
		logic        has_dest;
		tok_t        comp;
		tok_t        jump;
		logic        has_jump;
	} line_rec_t;

	typedef struct packed {
		logic       found;
		logic [6:0] code;
	} comp_hit_t;

	function automatic comp_hit_t comp_lookup(tok_t t);
		comp_hit_t   r;
		logic [25:0] key;
		key     = {t.len, t.chars};
		r.found = !t.too_long;
		r.code  = 7'h00;
		case (key)
			{2'd1, 16'h0, "0"}: r.code = 7'h2A;
			{2'd1, 16'h0, "1"}: r.code = 7'h3F;
			{2'd2, 8'h0, "-1"}: r.code = 7'h3A;
			{2'd1, 16'h0, "D"}: r.code = 7'h0C;
			{2'd1, 16'h0, "A"}: r.code = 7'h30;
			{2'd2, 8'h0, "!D"}: r.code = 7'h0D;
			{2'd2, 8'h0, "!A"}: r.code = 7'h31;
			{2'd2, 8'h0, "-D"}: r.code = 7'h0F;
			{2'd2, 8'h0, "-A"}: r.code = 7'h33;
			{2'd3, "D+1"}:      r.code = 7'h1F;
			{2'd3, "A+1"}:      r.code = 7'h37;
			{2'd3, "D-1"}:      r.code = 7'h0E;
			{2'd3, "A-1"}:      r.code = 7'h32;
			{2'd3, "D+A"}:      r.code = 7'h02;
			{2'd3, "D-A"}:      r.code = 7'h13;
			{2'd3, "A-D"}:      r.code = 7'h07;
			{2'd3, "D&A"}:      r.code = 7'h00;
			{2'd3, "D|A"}:      r.code = 7'h15;
			{2'd1, 16'h0, "M"}: r.code = 7'h70;
			{2'd2, 8'h0, "!M"}: r.code = 7'h71;
			{2'd2, 8'h0, "-M"}: r.code = 7'h73;
			{2'd3, "M+1"}:      r.code = 7'h77;
			{2'd3, "M-1"}:      r.code = 7'h72;
			{2'd3, "D+M"}:      r.code = 7'h42;
			{2'd3, "D-M"}:      r.code = 7'h53;
			{2'd3, "M-D"}:      r.code = 7'h47;
			{2'd3, "D&M"}:      r.code = 7'h40;
			{2'd3, "D|M"}:      r.code = 7'h55;
			default:            r.found = 1'b0;
		endcase
		if (!r.found) begin
			r.code = 7'h00;
		end
		return r;
	endfunction

	function automatic logic [2:0] dest_lookup(tok_t t);
		logic [2:0]  r;
		logic [25:0] key;
		key = {t.len, t.chars};
		case (key)
			{2'd1, 16'h0, "M"}: r = 3'd1;
			{2'd1, 16'h0, "D"}: r = 3'd2;
			{2'd2, 8'h0, "MD"}: r = 3'd3;
			{2'd1, 16'h0, "A"}: r = 3'd4;
			{2'd2, 8'h0, "AM"}: r = 3'd5;
			{2'd2, 8'h0, "AD"}: r = 3'd6;
			{2'd3, "AMD"}:      r = 3'd7;
			default:            r = 3'd0;
		endcase
		return t.too_long ? 3'd0 : r;
	endfunction

	function automatic logic [2:0] jump_lookup(tok_t t);
		logic [2:0]  r;
		logic [25:0] key;
		key = {t.len, t.chars};
		case (key)
			{2'd3, "JGT"}: r = 3'd1;
			{2'd3, "JEQ"}: r = 3'd2;
			{2'd3, "JGE"}: r = 3'd3;
			{2'd3, "JLT"}: r = 3'd4;
			{2'd3, "JNE"}: r = 3'd5;
			{2'd3, "JLE"}: r = 3'd6;
			{2'd3, "JMP"}: r = 3'd7;
			default:       r = 3'd0;
		endcase
		return t.too_long ? 3'd0 : r;
	endfunction

endpackage

/* design/ale_front.sv */
// ----------------------------------------------------------------------------
// ale_front
// Character front end: classifies the line, accumulates the address or splits
// dest=comp;jump tokens, and hands one line record to the queue at line end.
// ----------------------------------------------------------------------------
module ale_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  ale_pkg::in_t      char_item,
	output logic              rec_valid,
	input  logic              rec_ready,
	output ale_pkg::line_rec_t rec
);
	import ale_pkg::*;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_ADDR  = 2'd1;
	localparam logic [1:0] PH_COMP  = 2'd2;

	logic [1:0]  phase_q, phase_n;
	logic [15:0] addr_q, addr_n;
	logic        over_q, over_n;
	tok_t        cur_q, cur_n;
	tok_t        dest_q, dest_n;
	tok_t        comp_q, comp_n;
	logic        eq_q, eq_n;
	logic        semi_q, semi_n;
	logic [19:0] prod;
	logic [7:0]  c;
	logic        accept;

	assign c          = char_item.char_code;
	// only a line end needs room in the queue
	assign char_ready = rec_ready || !char_item.line_end;
	assign rec_valid  = char_valid && char_item.line_end;
	assign accept     = char_valid && char_ready;

	assign prod = {4'b0, addr_q} * 20'd10 + {16'b0, c[3:0]};

	always_comb begin
		phase_n = phase_q;
		addr_n  = addr_q;
		over_n  = over_q;
		cur_n   = cur_q;
		dest_n  = dest_q;
		comp_n  = comp_q;
		eq_n    = eq_q;
		semi_n  = semi_q;
		if (phase_q == PH_START) begin
			phase_n = (c == CH_AT) ? PH_ADDR : PH_COMP;
		end
		if (phase_q == PH_ADDR && c >= CH_0 && c <= CH_9) begin
			addr_n = prod[15:0];
			over_n = over_q | (prod[19:16] != 4'd0);
		end
		if (phase_n == PH_COMP) begin
			if (c == CH_EQ && !eq_q && !semi_q) begin
				eq_n   = 1'b1;
				dest_n = cur_q;
				cur_n  = '0;
			end else if (c == CH_SEMI && !semi_q) begin
				semi_n = 1'b1;
				comp_n = cur_q;
				cur_n  = '0;
			end else if (!cur_q.too_long) begin
				if (cur_q.len >= 2'(TOKEN_LIMIT)) begin
					cur_n.too_long = 1'b1;
				end else begin
					cur_n.chars = {cur_q.chars[15:0], c};
					cur_n.len   = cur_q.len + 2'd1;
				end
			end
		end
	end

	always_comb begin
		rec.is_addr   = (phase_n == PH_ADDR);
		rec.addr      = addr_n;
		rec.addr_over = over_n;
		rec.dest      = dest_n;
		rec.has_dest  = eq_n;
		// without ';' the open token is the comp
		rec.comp      = semi_n ? comp_n : cur_n;
		rec.jump      = cur_n;
		rec.has_jump  = semi_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			addr_q  <= '0;
			over_q  <= 1'b0;
			cur_q   <= '0;
			dest_q  <= '0;
			comp_q  <= '0;
			eq_q    <= 1'b0;
			semi_q  <= 1'b0;
		end else if (accept) begin
			if (char_item.line_end) begin
				phase_q <= PH_START;
				addr_q  <= '0;
				over_q  <= 1'b0;
				cur_q   <= '0;
				dest_q  <= '0;
				comp_q  <= '0;
				eq_q    <= 1'b0;
				semi_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				addr_q  <= addr_n;
				over_q  <= over_n;
				cur_q   <= cur_n;
				dest_q  <= dest_n;
				comp_q  <= comp_n;
				eq_q    <= eq_n;
				semi_q  <= semi_n;
			end
		end
	end

endmodule

/* design/ale_queue.sv */
// ----------------------------------------------------------------------------
// ale_queue
// Small register FIFO of line records between the front and the back end.
// ----------------------------------------------------------------------------
`include "assembly_line_encoder_unit_assert.svh"

module ale_queue #(
	parameter int unsigned DEPTH = ale_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  ale_pkg::line_rec_t push_rec,
	output logic               pop_valid,
	input  logic               pop_ready,
	output ale_pkg::line_rec_t pop_rec
);
	import ale_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	line_rec_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ALE_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "queue count above depth")
	`ALE_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == CW'($past(count_q) + 1'b1), "queue count did not grow on push")
	`ALE_ASSERT_NEXT(a_count_down, clk, arst_n, pop && !push, count_q == CW'($past(count_q) - 1'b1), "queue count did not shrink on pop")

endmodule

/* design/ale_back.sv */
// ----------------------------------------------------------------------------
// ale_back
// Back end: looks up the mnemonic tables for one line record and holds the
// encoded word in the output register until it is taken.
// ----------------------------------------------------------------------------
module ale_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	output logic               rec_ready,
	input  ale_pkg::line_rec_t rec,
	output logic               word_valid,
	input  logic               word_ready,
	output ale_pkg::out_t      word_item
);
	import ale_pkg::*;

	logic      valid_q;
	out_t      word_q;
	out_t      word_n;
	comp_hit_t chit;
	logic [2:0] dcode, jcode;

	assign rec_ready  = !valid_q || word_ready;
	assign word_valid = valid_q;
	assign word_item  = word_q;

	always_comb begin
		chit  = comp_lookup(rec.comp);
		dcode = rec.has_dest ? dest_lookup(rec.dest) : 3'd0;
		jcode = rec.has_jump ? jump_lookup(rec.jump) : 3'd0;
		if (rec.is_addr) begin
			word_n.machine_word     = rec.addr;
			word_n.comp_unknown     = 1'b0;
			word_n.address_overflow = rec.addr_over;
		end else begin
			word_n.machine_word     = {3'b111, chit.code, dcode, jcode};
			word_n.comp_unknown     = !chit.found;
			word_n.address_overflow = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid && rec_ready) begin
			word_q <= word_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_ready) begin
			valid_q <= rec_valid;
		end
	end

endmodule

/* design/assembly_line_encoder_unit.sv */
// ----------------------------------------------------------------------------
// assembly_line_encoder_unit
// Encodes Hack assembly lines, one character per transaction, into 16-bit
// instruction words.
// ----------------------------------------------------------------------------
// Usage:
//   char channel: one ASCII character per transaction; line_end marks the
//   last character of a line. Only that transaction produces a result.
//   word channel: one transaction per finished line with the machine word,
//   comp_unknown for C-lines and address_overflow for A-lines.
//   Path: the record of the line_end character is written into the line queue;
//   the word then becomes valid once the table lookup result is registered
//   in the output register.
//   Throughput: one character per cycle while word_ready is high, including
//   one-character lines; set by the front end's per-character token register.
//   Stall: while the receiver holds word_ready low, characters that do not
//   end a line keep flowing; a line_end character waits with char_ready low
//   once the line queue (DEPTH records) and the output register are full.
//   Reset: arst_n clears the line state, the queue and the output valid;
//   the first character after reset starts a new line.
// ----------------------------------------------------------------------------
module assembly_line_encoder_unit #(
	parameter int unsigned DEPTH = ale_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_ready,
	input  ale_pkg::in_t  char_item,
	output logic          word_valid,
	input  logic          word_ready,
	output ale_pkg::out_t word_item
);
	import ale_pkg::*;

	line_rec_t front_rec, back_rec;
	logic      front_valid, front_ready;
	logic      back_valid, back_ready;

	ale_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.rec_valid  (front_valid),
		.rec_ready  (front_ready),
		.rec        (front_rec)
	);

	ale_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_rec   (front_rec),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_rec    (back_rec)
	);

	ale_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (back_valid),
		.rec_ready  (back_ready),
		.rec        (back_rec),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_item  (word_item)
	);

endmodule
